FILE: hdl/swaf_pkg.sv
// ----------------------------------------------------------------------------
// swaf_pkg
// Shared constants, codes and types of the sliding window anagram finder.
// ----------------------------------------------------------------------------
`default_nettype none

package swaf_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int MAX_PATTERN   = 256;
    localparam int MAX_TEXT      = 1048576;

    localparam int MODE_W   = 2;
    localparam int LETTER_W = 5;
    localparam int START_W  = 20;
    localparam int COUNT_W  = $clog2(MAX_PATTERN + 1);
    localparam int HIST_AW  = $clog2(MAX_PATTERN);
    localparam int POS_W    = $clog2(MAX_TEXT + 1);

    localparam int OPQ_DEPTH  = 4;
    localparam int OUTQ_DEPTH = 4;

    // input modes
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd2;

    // operation kinds passed from front to back
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [KIND_W-1:0] OP_PATTERN = 2'd1;
    localparam logic [KIND_W-1:0] OP_TEXT    = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [LETTER_W-1:0] sym;
        logic                remove;
        logic [HIST_AW-1:0]  rd_addr;
        logic [HIST_AW-1:0]  wr_addr;
        logic                emit;
        logic [START_W-1:0]  start;
    } swaf_op_t;

    typedef logic [ALPHABET_SIZE-1:0][COUNT_W-1:0] swaf_counts_t;

endpackage

`default_nettype wire

FILE: hdl/swaf_ram.sv
// ----------------------------------------------------------------------------
// swaf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module swaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first on an address collision
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/swaf_front.sv
// ----------------------------------------------------------------------------
// swaf_front
// Accept items, track lengths and positions, and classify each item into
// an operation for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module swaf_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic                          q_full,
    input  wire logic [swaf_pkg::MODE_W-1:0]   mode,
    input  wire logic [swaf_pkg::LETTER_W-1:0] letter,
    output logic                               op_push,
    output swaf_pkg::swaf_op_t                 op
);
    import swaf_pkg::*;

    logic [COUNT_W-1:0] plen_reg, plen_next;
    logic [POS_W-1:0]   tp_reg, tp_next;
    logic [HIST_AW-1:0] hp_reg, hp_next;
    logic               accept;
    logic               letter_ok;
    logic               op_valid;
    logic [POS_W-1:0]   tp_inc;
    logic [POS_W-1:0]   plen_ext;
    logic [POS_W-1:0]   start_full;

    assign accept     = push && !q_full;
    assign letter_ok  = letter < LETTER_W'(ALPHABET_SIZE);
    assign tp_inc     = tp_reg + POS_W'(1);
    assign plen_ext   = POS_W'(plen_reg);
    assign start_full = tp_inc - plen_ext;

    always_comb
    begin
        plen_next    = plen_reg;
        tp_next      = tp_reg;
        hp_next      = hp_reg;
        op_valid     = 1'b0;
        op.kind      = OP_CLEAR;
        op.sym       = letter;
        op.remove    = tp_reg >= plen_ext;
        op.rd_addr   = hp_reg - plen_reg[HIST_AW-1:0];
        op.wr_addr   = hp_reg;
        op.emit      = tp_inc >= plen_ext;
        op.start     = start_full[START_W-1:0];
        case (mode)
            MODE_CLEAR:
            begin
                op_valid  = 1'b1;
                plen_next = '0;
                tp_next   = '0;
                hp_next   = '0;
            end
            MODE_PATTERN:
            begin
                if (letter_ok && tp_reg == '0 && plen_reg < COUNT_W'(MAX_PATTERN))
                begin
                    op_valid  = 1'b1;
                    op.kind   = OP_PATTERN;
                    plen_next = plen_reg + COUNT_W'(1);
                end
            end
            MODE_TEXT:
            begin
                if (letter_ok && tp_reg < POS_W'(MAX_TEXT))
                begin
                    tp_next = tp_inc;
                    // with no pattern, only advance the position
                    if (plen_reg != '0)
                    begin
                        op_valid = 1'b1;
                        op.kind  = OP_TEXT;
                        hp_next  = hp_reg + HIST_AW'(1);
                    end
                end
            end
            default:
            begin
                op_valid = 1'b0;
            end
        endcase
    end

    assign op_push = accept && op_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= '0;
            tp_reg   <= '0;
            hp_reg   <= '0;
        end
        else if (accept)
        begin
            plen_reg <= plen_next;
            tp_reg   <= tp_next;
            hp_reg   <= hp_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/swaf_op_queue.sv
// ----------------------------------------------------------------------------
// swaf_op_queue
// Short queue of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module swaf_op_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire swaf_pkg::swaf_op_t wr_op,
    output logic                    full,
    input  wire logic               rd_en,
    output swaf_pkg::swaf_op_t      rd_op,
    output logic                    empty
);
    import swaf_pkg::*;

    localparam int AW = $clog2(OPQ_DEPTH);
    localparam int CW = $clog2(OPQ_DEPTH + 1);

    swaf_op_t        mem_reg [OPQ_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_wr;
    logic            do_rd;

    assign full  = cnt_reg == CW'(OPQ_DEPTH);
    assign empty = cnt_reg == '0;
    assign rd_op = mem_reg[rd_ptr_reg];
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/swaf_back.sv
// ----------------------------------------------------------------------------
// swaf_back
// Carry out operations: history access, letter count update, window
// compare, and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module swaf_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_empty,
    input  wire swaf_pkg::swaf_op_t           q_op,
    output logic                              q_pop,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [swaf_pkg::START_W-1:0]      start_index
);
    import swaf_pkg::*;

    localparam int OAW = $clog2(OUTQ_DEPTH);
    localparam int OCW = $clog2(OUTQ_DEPTH + 1);
    localparam int LW  = OCW + 1;

    // stage B: history data arrives, counts update
    logic                b_valid_reg;
    swaf_op_t            b_op_reg;
    logic [LETTER_W-1:0] gone;

    // stage C: compare
    logic                c_valid_reg;
    logic                c_emit_reg;
    logic [START_W-1:0]  c_start_reg;
    logic                match;

    swaf_counts_t        pat_reg, pat_next;
    swaf_counts_t        win_reg, win_next;

    // result queue
    logic [START_W-1:0]  oq_reg [OUTQ_DEPTH];
    logic [OAW-1:0]      oq_wr_reg;
    logic [OAW-1:0]      oq_rd_reg;
    logic [OCW-1:0]      oq_cnt_reg, oq_cnt_next;
    logic                oq_push;
    logic                oq_pop;
    logic [LW-1:0]       level;

    // reserve queue room for everything in flight
    assign level = LW'(oq_cnt_reg) + LW'(b_valid_reg) + LW'(c_valid_reg);
    assign q_pop = !q_empty && (level < LW'(OUTQ_DEPTH));

    swaf_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (MAX_PATTERN)
    ) u_hist (
        .clk   (clk),
        .we    (q_pop && q_op.kind == OP_TEXT),
        .waddr (q_op.wr_addr),
        .wdata (q_op.sym),
        .raddr (q_op.rd_addr),
        .rdata (gone)
    );

    always_comb
    begin
        pat_next = pat_reg;
        win_next = win_reg;
        if (b_valid_reg)
        begin
            case (b_op_reg.kind)
                OP_CLEAR:
                begin
                    pat_next = '0;
                    win_next = '0;
                end
                OP_PATTERN:
                begin
                    pat_next[b_op_reg.sym] = pat_reg[b_op_reg.sym] + COUNT_W'(1);
                end
                OP_TEXT:
                begin
                    // drop the oldest letter, then add the new one
                    if (b_op_reg.remove && gone < LETTER_W'(ALPHABET_SIZE)
                        && win_reg[gone] != '0)
                    begin
                        win_next[gone] = win_reg[gone] - COUNT_W'(1);
                    end
                    win_next[b_op_reg.sym] = win_next[b_op_reg.sym] + COUNT_W'(1);
                end
                default:
                begin
                    pat_next = pat_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        match = 1'b1;
        for (int k = 0; k < ALPHABET_SIZE; k++)
        begin
            if (pat_reg[k] != win_reg[k])
            begin
                match = 1'b0;
            end
        end
    end

    assign oq_push     = c_valid_reg && c_emit_reg && match;
    assign empty       = oq_cnt_reg == '0;
    assign oq_pop      = pop && !empty;
    assign start_index = oq_reg[oq_rd_reg];

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg;
        if (oq_push && !oq_pop)
        begin
            oq_cnt_next = oq_cnt_reg + OCW'(1);
        end
        else if (oq_pop && !oq_push)
        begin
            oq_cnt_next = oq_cnt_reg - OCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        b_op_reg    <= q_op;
        c_start_reg <= b_op_reg.start;
        if (oq_push)
        begin
            oq_reg[oq_wr_reg] <= c_start_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            c_emit_reg  <= 1'b0;
            pat_reg     <= '0;
            win_reg     <= '0;
            oq_wr_reg   <= '0;
            oq_rd_reg   <= '0;
            oq_cnt_reg  <= '0;
        end
        else
        begin
            b_valid_reg <= q_pop;
            c_valid_reg <= b_valid_reg;
            c_emit_reg  <= b_valid_reg && b_op_reg.kind == OP_TEXT && b_op_reg.emit;
            pat_reg     <= pat_next;
            win_reg     <= win_next;
            oq_cnt_reg  <= oq_cnt_next;
            if (oq_push)
            begin
                oq_wr_reg <= (oq_wr_reg == OAW'(OUTQ_DEPTH - 1)) ? '0 : oq_wr_reg + OAW'(1);
            end
            if (oq_pop)
            begin
                oq_rd_reg <= (oq_rd_reg == OAW'(OUTQ_DEPTH - 1)) ? '0 : oq_rd_reg + OAW'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sliding_window_anagram_finder.sv
// ----------------------------------------------------------------------------
// sliding_window_anagram_finder
// Report every text position where a window of pattern length is an
// anagram of the pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive mode and letter, raise push; the item transfers
//   on a clock edge with push high and full low. Mode clear wipes the
//   counts, lengths and positions, mode pattern adds a pattern letter (only
//   before any text), mode text slides the window by one letter.
//   Result queue side: while empty is low, start_index holds the oldest
//   match position; it transfers on an edge with pop high.
//   Throughput: one item per cycle sustained while the result side keeps
//   up. The rate is set by the per-letter count update, which retires one
//   letter per cycle together with one read and one write on the two-port
//   history RAM. Path: a matching text letter passes the queue, history
//   read, count update and compare before it shows up on the result side.
//   Reset: rst_n clears counts, lengths, positions and both queues at once;
//   the history RAM is not cleared and needs no sweep, since only letters
//   written since the last clear are ever read.
//   Stall: when pop stays low, the result queue fills, the back end holds,
//   the operation queue fills, and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_anagram_finder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [swaf_pkg::MODE_W-1:0]   mode,
    input  wire logic [swaf_pkg::LETTER_W-1:0] letter,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [swaf_pkg::START_W-1:0]       start_index
);
    import swaf_pkg::*;

    // classified operation from front to queue, and queue to back
    logic     op_push;
    swaf_op_t front_op;
    swaf_op_t queue_op;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;

    assign full = q_full;

    // Front: hold pattern length, text position and history pointer;
    // drop items that change nothing.
    swaf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .q_full  (q_full),
        .mode    (mode),
        .letter  (letter),
        .op_push (op_push),
        .op      (front_op)
    );

    // Decouple the two halves so each side can stall on its own.
    swaf_op_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (op_push),
        .wr_op (front_op),
        .full  (q_full),
        .rd_en (q_pop),
        .rd_op (queue_op),
        .empty (q_empty)
    );

    // Back: advance the window counts and compare against the pattern.
    swaf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_op        (queue_op),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .start_index (start_index)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        op_push |-> !q_full)
        else $error("operation pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("operation popped from an empty queue");

    a_clear_forwarded: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && mode == MODE_CLEAR) |-> op_push)
        else $error("clear not forwarded to the back end");

    a_clear_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && mode == MODE_CLEAR) |=> !q_empty)
        else $error("queue empty right after a clear transfer");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding window anagram finder: a directed
// table and random pattern/text sequences, one of them with a full-size
// pattern, scored against an in-bench model of the letter counts and the
// window, or for typed table rows against the result the row gives.
// ----------------------------------------------------------------------------

module tb;

    import swaf_pkg::*;

    // Mode code the block must ignore.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // Generous bound: far above what a correct run needs.
    localparam int CYCLE_LIMIT  = 200_000;
    // Wait well past the pipeline depth before the verdict.
    localparam int DRAIN_CYCLES = 32;

    // One row of the directed table. When typed is set, hit/start give the
    // expected result directly; otherwise the model decides.
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [LETTER_W-1:0] letter;
        logic                typed;
        logic                hit;
        logic [START_W-1:0]  start;
    } stim_row_t;

    logic                clk    = 1'b0;
    logic                rst_n  = 1'b0;
    logic                push   = 1'b0;
    logic [MODE_W-1:0]   mode   = MODE_CLEAR;
    logic [LETTER_W-1:0] letter = '0;
    logic                pop    = 1'b0;
    logic                full;
    logic                empty;
    logic [START_W-1:0]  start_index;

    sliding_window_anagram_finder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .letter      (letter),
        .empty       (empty),
        .pop         (pop),
        .start_index (start_index)
    );

    // ------------------------------------------------------------------
    // Model state: letter counts of the pattern and of the window, the
    // ring of recent text letters and the text position since the last
    // clear.
    // ------------------------------------------------------------------
    int                  pat_cnt [ALPHABET_SIZE];
    int                  win_cnt [ALPHABET_SIZE];
    int                  pat_len;
    int                  text_pos;
    logic [LETTER_W-1:0] hist_mem [MAX_PATTERN];
    logic [HIST_AW-1:0]  hist_wr;

    // Window start positions still owed by the block, oldest first.
    logic [START_W-1:0]  match_starts_q [$];

    stim_row_t           directed_rows [$];

    int errors        = 0;
    int items_sent    = 0;
    int cycles        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Return counts, lengths and pointers to their cleared values. The
    // ring itself keeps stale letters; they are never read after a clear.
    function automatic void clear_windows();
        for (int k = 0; k < ALPHABET_SIZE; k++)
        begin
            pat_cnt[k] = 0;
            win_cnt[k] = 0;
        end
        pat_len  = 0;
        text_pos = 0;
        hist_wr  = '0;
    endfunction

    // Advance the model by one transferred item; return 1 with the window
    // start when the item completes a window that is an anagram.
    function automatic bit predict_match(input logic [MODE_W-1:0] m,
                                         input logic [LETTER_W-1:0] l,
                                         output logic [START_W-1:0] start);
        logic [HIST_AW-1:0]  oldest;
        logic [LETTER_W-1:0] gone;
        bit                  same;
        start = '0;
        if (m == MODE_CLEAR)
        begin
            clear_windows();
            return 1'b0;
        end
        if (m != MODE_PATTERN && m != MODE_TEXT)
            return 1'b0;
        if (l >= ALPHABET_SIZE)
            return 1'b0;
        if (m == MODE_PATTERN)
        begin
            // Drop pattern letters once text has begun or the pattern is full.
            if (text_pos != 0 || pat_len >= MAX_PATTERN)
                return 1'b0;
            pat_cnt[l]++;
            pat_len++;
            return 1'b0;
        end
        if (text_pos >= MAX_TEXT)
            return 1'b0;
        if (pat_len == 0)
        begin
            text_pos++;
            return 1'b0;
        end
        // Window full: remove the letter that slides out. The ring index
        // wraps at its own width, so pattern length 256 reads the slot
        // about to be overwritten.
        if (text_pos >= pat_len)
        begin
            oldest = hist_wr - HIST_AW'(pat_len);
            gone   = hist_mem[oldest];
            if (win_cnt[gone] > 0)
                win_cnt[gone]--;
        end
        hist_mem[hist_wr] = l;
        hist_wr++;
        win_cnt[l]++;
        text_pos++;
        if (text_pos < pat_len)
            return 1'b0;
        same = 1'b1;
        for (int k = 0; k < ALPHABET_SIZE; k++)
            if (pat_cnt[k] != win_cnt[k])
                same = 1'b0;
        if (same)
            start = START_W'(text_pos - pat_len);
        return same;
    endfunction

    function automatic stim_row_t row(input logic [MODE_W-1:0] m,
                                      input logic [LETTER_W-1:0] l,
                                      input logic typed,
                                      input logic hit,
                                      input logic [START_W-1:0] start);
        stim_row_t r;
        r.mode   = m;
        r.letter = l;
        r.typed  = typed;
        r.hit    = hit;
        r.start  = start;
        return r;
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(input stim_row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop if the block hangs or stops producing.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("sliding_window_anagram_finder: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: score each transfer against the oldest owed start,
    // then decide at random whether to pop in the next cycle. All reads
    // here see the values from before the edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_side
        logic [START_W-1:0] want;
        if (rst_n && pop && !empty)
        begin
            if (match_starts_q.size() == 0)
            begin
                $display("%0t: start_index expected none, got %0d", $time, start_index);
                errors++;
            end
            else
            begin
                want = match_starts_q.pop_front();
                if (start_index !== want)
                begin
                    $display("%0t: start_index expected %0d, got %0d",
                             $time, want, start_index);
                    errors++;
                end
            end
        end
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Present one item, hold it until it transfers, then log what the
    // model (or the typed row) says it owes.
    task automatic send_item(input logic [MODE_W-1:0] m,
                             input logic [LETTER_W-1:0] l,
                             input bit typed,
                             input bit typed_hit,
                             input logic [START_W-1:0] typed_start);
        bit                 hit;
        logic [START_W-1:0] start;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push   <= 1'b1;
        mode   <= m;
        letter <= l;
        @(posedge clk);
        while (full)
            @(posedge clk);
        hit = predict_match(m, l, start);
        if (typed)
        begin
            hit   = typed_hit;
            start = typed_start;
        end
        if (hit)
            match_starts_q.insert(match_starts_q.size(), start);
        items_sent++;
    endtask

    // Inject one disturbing item: unused mode, letter codes past the
    // alphabet, a late pattern letter, or now and then a clear that cuts
    // the sequence short.
    task automatic send_noise();
        case ($urandom_range(7))
            0:       send_item(MODE_CLEAR, LETTER_W'($urandom_range(31)), 0, 0, '0);
            1, 2:    send_item(MODE_SPARE, LETTER_W'($urandom_range(31)), 0, 0, '0);
            3, 4:    send_item(MODE_TEXT,
                               LETTER_W'($urandom_range(ALPHABET_SIZE, 31)), 0, 0, '0);
            5:       send_item(MODE_PATTERN,
                               LETTER_W'($urandom_range(ALPHABET_SIZE, 31)), 0, 0, '0);
            default: send_item(MODE_PATTERN,
                               LETTER_W'($urandom_range(ALPHABET_SIZE - 1)), 0, 0, '0);
        endcase
    endtask

    task automatic send_letter(input logic [MODE_W-1:0] m,
                               input logic [LETTER_W-1:0] l,
                               input bit quiet);
        if (!quiet && $urandom_range(19) == 0)
            send_noise();
        send_item(m, l, 0, 0, '0);
    endtask

    // One pattern followed by text built from chunks: shuffled copies of
    // the pattern (aligned matches), draws from the pattern's letters
    // (frequent sliding matches) or free letters. The big form loads a
    // pattern past the limit and slides the window across the ring wrap.
    task automatic run_sequence(input bit big);
        logic [LETTER_W-1:0] pat  [$];
        logic [LETTER_W-1:0] deck [$];
        logic [LETTER_W-1:0] tmp;
        int plen;
        int chunks;
        int pick;
        int n;
        if (big || $urandom_range(9) != 0)
            send_item(MODE_CLEAR, LETTER_W'($urandom_range(31)), 0, 0, '0);
        if (big)
            plen = MAX_PATTERN + $urandom_range(1, 6);
        else if ($urandom_range(15) == 0)
            plen = 0;
        else if ($urandom_range(3) == 0)
            plen = $urandom_range(1, 24);
        else
            plen = $urandom_range(1, 5);
        for (int k = 0; k < plen; k++)
        begin
            tmp = LETTER_W'($urandom_range(ALPHABET_SIZE - 1));
            if (pat.size() < MAX_PATTERN)
                pat.insert(pat.size(), tmp);
            send_letter(MODE_PATTERN, tmp, big);
        end
        chunks = big ? 3 : $urandom_range(1, 6);
        for (int j = 0; j < chunks; j++)
        begin
            if (pat.size() == 0)
                pick = 2;
            else if (big)
                pick = 0;
            else
                pick = $urandom_range(2);
            deck.delete();
            case (pick)
                0:
                begin
                    deck = pat;
                    for (int k = deck.size() - 1; k > 0; k--)
                    begin
                        n       = $urandom_range(k);
                        tmp     = deck[k];
                        deck[k] = deck[n];
                        deck[n] = tmp;
                    end
                end
                1:
                begin
                    for (int k = 0; k < pat.size(); k++)
                        deck.insert(deck.size(), pat[$urandom_range(pat.size() - 1)]);
                end
                default:
                begin
                    n = $urandom_range(1, 8);
                    for (int k = 0; k < n; k++)
                        deck.insert(deck.size(),
                                    LETTER_W'($urandom_range(ALPHABET_SIZE - 1)));
                end
            endcase
            foreach (deck[k])
                send_letter(MODE_TEXT, deck[k], big);
        end
    endtask

    initial
    begin
        clear_windows();

        // Directed table; typed rows carry results plain from the rules.
        // Text with an empty pattern straight after reset: position only.
        add_row(row(MODE_TEXT,    5'd0,  1, 0, '0));
        // Clear ignores its letter.
        add_row(row(MODE_CLEAR,   5'd31, 1, 0, '0));
        add_row(row(MODE_PATTERN, 5'd0,  1, 0, '0));
        add_row(row(MODE_PATTERN, 5'd25, 1, 0, '0));
        // Letter past the alphabet and the unused mode: no effect.
        add_row(row(MODE_PATTERN, 5'd31, 1, 0, '0));
        add_row(row(MODE_SPARE,   5'd16, 1, 0, '0));
        // Window not yet full.
        add_row(row(MODE_TEXT,    5'd25, 1, 0, '0));
        add_row(row(MODE_TEXT,    5'd0,  1, 1, 20'd0));
        // Pattern letter after text has begun: dropped.
        add_row(row(MODE_PATTERN, 5'd1,  1, 0, '0));
        add_row(row(MODE_TEXT,    5'd25, 1, 1, 20'd1));
        add_row(row(MODE_TEXT,    5'd26, 1, 0, '0));
        add_row(row(MODE_TEXT,    5'd1,  0, 0, '0));
        add_row(row(MODE_TEXT,    5'd0,  0, 0, '0));
        add_row(row(MODE_TEXT,    5'd25, 0, 0, '0));
        add_row(row(MODE_CLEAR,   5'd0,  1, 0, '0));
        add_row(row(MODE_PATTERN, 5'd16, 1, 0, '0));
        add_row(row(MODE_TEXT,    5'd16, 1, 1, 20'd0));
        add_row(row(MODE_TEXT,    5'd15, 1, 0, '0));
        add_row(row(MODE_TEXT,    5'd16, 0, 0, '0));
        add_row(row(MODE_SPARE,   5'd31, 1, 0, '0));
        add_row(row(MODE_CLEAR,   5'd0,  0, 0, '0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: sender idles lightly, receiver heavily.
        send_idle_pct = 28;
        recv_idle_pct = 47;
        foreach (directed_rows[i])
            send_item(directed_rows[i].mode, directed_rows[i].letter,
                      directed_rows[i].typed, directed_rows[i].hit,
                      directed_rows[i].start);
        while (items_sent < 500)
            run_sequence(0);

        // Phase two: swap the idle rates; start with the full-size pattern.
        send_idle_pct = 47;
        recv_idle_pct = 28;
        run_sequence(1);
        while (items_sent < 1500)
            run_sequence(0);

        // Phase three: back to back on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (items_sent < 2000)
            run_sequence(0);
        push <= 1'b0;

        // Drain owed results, then watch for strays.
        while (match_starts_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("sliding_window_anagram_finder: match");
        else
            $display("sliding_window_anagram_finder: mismatch");
        $finish;
    end

endmodule
